/* rtl/core/pgs_pkg.sv */
// Shared types, constants and helpers for the particle gravity step unit.
// Depends on nothing; pgs_front and the top level import it.
package pgs_pkg;

	localparam int MAX_BODIES_DEF = 8;

	// G * dt = 1e-5 in unsigned Q0.48, truncated
	localparam logic [31:0] GDT_Q48 = 32'd2814749767;
	// per-axis velocity step limit, 1.0 * 2^32 in Q16.16 terms
	localparam logic [32:0] TERM_CAP = 33'h1_0000_0000;
	// unit length in Q2.30
	localparam logic [30:0] UNIT_Q30 = 31'h4000_0000;

	typedef enum logic [1:0] {
		CFG_OFFSET_X   = 2'd0,
		CFG_OFFSET_Y   = 2'd1,
		CFG_OFFSET_Z   = 2'd2,
		CFG_BODY_COUNT = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_UPDATE = 1'b1
	} op_t;

	typedef struct packed {
		logic              operation;
		logic [2:0]        body_index;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic [31:0]       mass;
	} item_t;

	typedef struct packed {
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_pos_z;
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic signed [31:0] new_vel_z;
	} result_t;

	// one body interaction token; index 0 is x
	typedef struct packed {
		logic             first;
		logic             last;
		logic             none;
		logic [2:0][31:0] pos;
		logic [2:0][31:0] vel;
	} tok_t;

	// front end result handed to the root and divide pipes
	typedef struct packed {
		tok_t             tok;
		logic             skip;
		logic [2:0][31:0] rmag;
		logic [2:0]       rneg;
		logic [63:0]      t;
		logic [63:0]      d2;
	} fb_t;

	// sideband of the acceleration divider
	typedef struct packed {
		tok_t tok;
		logic skip;
	} ab_t;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -36'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

/* rtl/core/pgs_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, NW stages.
// Standalone; carries a sideband word alongside each quotient.
module pgs_div_pipe #(
	parameter int NW = 64,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  logic [NW-1:0] num,
	input  logic [NW-1:0] den,
	input  logic [SW-1:0] sb_i,
	output logic          vld_o,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] sb_o
);

	logic          vld_s [1:NW];
	logic [NW-1:0] rem_s [1:NW];
	logic [NW-1:0] num_s [1:NW];
	logic [NW-1:0] den_s [1:NW];
	logic [NW-1:0] quo_s [1:NW];
	logic [SW-1:0] sb_s  [1:NW];

	for (genvar i = 1; i <= NW; i++) begin : g_st
		logic          vld_c;
		logic [NW-1:0] rem_c, num_c, den_c, quo_c;
		logic [SW-1:0] sb_c;
		logic [NW:0]   trial, diff;
		logic          ge;

		if (i == 1) begin : g_src
			assign vld_c = vld_i;
			assign rem_c = '0;
			assign num_c = num;
			assign den_c = den;
			assign quo_c = '0;
			assign sb_c  = sb_i;
		end else begin : g_src
			assign vld_c = vld_s[i-1];
			assign rem_c = rem_s[i-1];
			assign num_c = num_s[i-1];
			assign den_c = den_s[i-1];
			assign quo_c = quo_s[i-1];
			assign sb_c  = sb_s[i-1];
		end

		assign trial = {rem_c, num_c[NW-1]};
		assign ge    = trial >= {1'b0, den_c};
		assign diff  = trial - {1'b0, den_c};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? diff[NW-1:0] : trial[NW-1:0];
				num_s[i] <= {num_c[NW-2:0], 1'b0};
				den_s[i] <= den_c;
				quo_s[i] <= {quo_c[NW-2:0], ge};
				sb_s[i]  <= sb_c;
			end
		end
	end

	assign vld_o = vld_s[NW];
	assign quo   = quo_s[NW];
	assign sb_o  = sb_s[NW];

endmodule

/* rtl/core/pgs_sqrt_pipe.sv */
// Pipelined integer square root, one root bit per stage, RW stages.
// Standalone; carries a sideband word alongside each root.
module pgs_sqrt_pipe #(
	parameter int RW = 32,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  logic [2*RW-1:0] x,
	input  logic [SW-1:0]   sb_i,
	output logic            vld_o,
	output logic [RW-1:0]   root,
	output logic [SW-1:0]   sb_o
);

	localparam int XW = 2 * RW;

	logic          vld_s [1:RW];
	logic [XW-1:0] x_s   [1:RW];
	logic [XW-1:0] res_s [1:RW];
	logic [SW-1:0] sb_s  [1:RW];

	for (genvar i = 1; i <= RW; i++) begin : g_st
		localparam logic [XW-1:0] BIT = XW'(1) << (XW - 2 * i);
		logic          vld_c;
		logic [XW-1:0] x_c, res_c, trial;
		logic [SW-1:0] sb_c;
		logic          ge;

		if (i == 1) begin : g_src
			assign vld_c = vld_i;
			assign x_c   = x;
			assign res_c = '0;
			assign sb_c  = sb_i;
		end else begin : g_src
			assign vld_c = vld_s[i-1];
			assign x_c   = x_s[i-1];
			assign res_c = res_s[i-1];
			assign sb_c  = sb_s[i-1];
		end

		assign trial = res_c + BIT;
		assign ge    = x_c >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i]   <= ge ? x_c - trial : x_c;
				res_s[i] <= ge ? (res_c >> 1) + BIT : res_c >> 1;
				sb_s[i]  <= sb_c;
			end
		end
	end

	assign vld_o = vld_s[RW];
	assign root  = res_s[RW][RW-1:0];
	assign sb_o  = sb_s[RW];

endmodule

/* rtl/core/pgs_front.sv */
// Body table, particle sequencer and the first four pipeline stages:
// offset distance, mass product, squared distance and force numerator. Uses pgs_pkg.
module pgs_front import pgs_pkg::*; #(
	parameter int MAX_BODIES = MAX_BODIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               item_valid,
	input  item_t              item,
	output logic               item_stall,
	input  logic signed [31:0] offset_x,
	input  logic signed [31:0] offset_y,
	input  logic signed [31:0] offset_z,
	input  logic [3:0]         body_count,
	output logic               fb_vld,
	output fb_t                fb
);

	localparam int CW = $clog2(MAX_BODIES + 1);
	localparam int IW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;

	logic               busy_q;
	logic [CW-1:0]      k_q, n_q, n_in;
	logic [2:0][31:0]   pos_q, vel_q;
	logic [31:0]        pm_q;
	logic signed [33:0] poff_q [3];

	logic accept, load, upd, issue, last_k, idx_ok;
	logic [IW-1:0] widx, ridx;

	logic [31:0] mem_x [MAX_BODIES];
	logic [31:0] mem_y [MAX_BODIES];
	logic [31:0] mem_z [MAX_BODIES];
	logic [31:0] mem_m [MAX_BODIES];

	assign item_stall = busy_q || !en;
	assign accept     = item_valid && !item_stall;
	assign load       = accept && (op_t'(item.operation) == OP_LOAD);
	assign upd        = accept && (op_t'(item.operation) == OP_UPDATE);
	assign issue      = busy_q && en;
	assign last_k     = (32'(k_q) + 32'd1) >= 32'(n_q);
	assign idx_ok     = 32'(item.body_index) < MAX_BODIES;
	assign widx       = IW'(item.body_index);
	assign ridx       = IW'(k_q);

	always_comb begin
		if (32'(body_count) > MAX_BODIES) begin
			n_in = CW'(MAX_BODIES);
		end else begin
			n_in = CW'(body_count);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
			n_q    <= '0;
		end else if (upd) begin
			busy_q <= 1'b1;
			k_q    <= '0;
			n_q    <= n_in;
		end else if (issue) begin
			if (last_k) begin
				busy_q <= 1'b0;
			end else begin
				k_q <= k_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			pos_q     <= {item.pos_z, item.pos_y, item.pos_x};
			vel_q     <= {item.vel_z, item.vel_y, item.vel_x};
			pm_q      <= item.mass;
			poff_q[0] <= 34'(item.pos_x) + 34'(offset_x);
			poff_q[1] <= 34'(item.pos_y) + 34'(offset_y);
			poff_q[2] <= 34'(item.pos_z) + 34'(offset_z);
		end
	end

	always_ff @(posedge clk) begin
		if (load && idx_ok) begin
			mem_x[widx] <= item.pos_x;
			mem_y[widx] <= item.pos_y;
			mem_z[widx] <= item.pos_z;
			mem_m[widx] <= item.mass;
		end
	end

	// stage 1: table read
	logic               vld_s1;
	tok_t               tok_s1;
	logic [2:0][31:0]   b_s1;
	logic [31:0]        bm_s1, pm_s1;
	logic signed [33:0] poff_s1 [3];

	always_ff @(posedge clk) begin
		if (issue) begin
			b_s1[0] <= mem_x[ridx];
			b_s1[1] <= mem_y[ridx];
			b_s1[2] <= mem_z[ridx];
			bm_s1   <= mem_m[ridx];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			tok_s1 <= '{first: (k_q == '0), last: last_k, none: (n_q == '0),
				pos: pos_q, vel: vel_q};
			pm_s1  <= pm_q;
			for (int j = 0; j < 3; j++) begin
				poff_s1[j] <= poff_q[j];
			end
		end
	end

	// stage 2: distance and mass product
	logic               vld_s2;
	tok_t               tok_s2;
	logic signed [31:0] r_s2 [3];
	logic [63:0]        mm_s2, mm_c;

	assign mm_c = 64'(bm_s1) * 64'(pm_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			tok_s2 <= tok_s1;
			mm_s2  <= mm_c;
			for (int j = 0; j < 3; j++) begin
				r_s2[j] <= sat32(36'($signed(b_s1[j])) - 36'(poff_s1[j]));
			end
		end
	end

	// stage 3: squares and force numerator partials
	logic               vld_s3;
	tok_t               tok_s3;
	logic [63:0]        sq_s3 [3];
	logic [2:0][31:0]   rmag_s3;
	logic [2:0]         rneg_s3;
	logic               rzero_s3;
	logic [63:0]        kl_s3, kh_s3, kl_c, kh_c;
	logic signed [63:0] sq_c [3];

	assign kl_c = 64'(GDT_Q48) * 64'(mm_s2[31:0]);
	assign kh_c = 64'(GDT_Q48) * 64'(mm_s2[63:32]);

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sq_c[j] = 64'(r_s2[j]) * 64'(r_s2[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_s3   <= tok_s2;
			kl_s3    <= kl_c;
			kh_s3    <= kh_c;
			rzero_s3 <= (r_s2[0] == '0) && (r_s2[1] == '0) && (r_s2[2] == '0);
			for (int j = 0; j < 3; j++) begin
				sq_s3[j]   <= sq_c[j];
				rneg_s3[j] <= r_s2[j][31];
				rmag_s3[j] <= r_s2[j][31] ? (~r_s2[j] + 32'd1) : r_s2[j];
			end
		end
	end

	// stage 4: squared length and force numerator
	logic vld_s4;
	fb_t  fb_s4;
	logic [64:0] t_c;

	assign t_c = 65'(kh_s3) + 65'(kl_s3[63:32]);

	always_ff @(posedge clk) begin
		if (en) begin
			fb_s4.tok  <= tok_s3;
			fb_s4.skip <= tok_s3.none || rzero_s3;
			fb_s4.rmag <= rmag_s3;
			fb_s4.rneg <= rneg_s3;
			fb_s4.t    <= t_c[63:0];
			fb_s4.d2   <= sq_s3[0] + sq_s3[1] + sq_s3[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign fb_vld = vld_s4;
	assign fb     = fb_s4;

`ifndef SYNTHESIS
	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (k_q < n_q) || (n_q == '0))
		else $error("body counter ran past body count");
	a_tok_none: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && tok_s1.none |-> tok_s1.first && tok_s1.last)
		else $error("empty particle token is not a single token");
	a_issue_end: assert property (@(posedge clk) disable iff (!arst_n)
		issue && last_k |=> !busy_q)
		else $error("sequencer kept issuing after its last body");
`endif

endmodule

/* rtl/core/particle_gravity_step_unit.sv */
// Top level of the particle gravity step unit: config registers, root and divide
// pipes, force scaling, velocity accumulation and the result register. Uses pgs_pkg.
//
//  channel   signals                          word
//  --------  -------------------------------  ---------------------------------
//  item      item_valid / item_stall / item   body load or particle (item_t)
//  result    result_valid / result_stall      updated particle (result_t)
//  cfg       cfg_wen / cfg_index / cfg_data   offset_x/y/z, body_count
//
// A particle issues max(1, min(body_count, MAX_BODIES)) tokens, one table body
// per cycle while the result is not stalled; a body load writes the table on accept.
// From particle accept to result valid a token passes four front stages, 32 root
// stages, 64 divide stages, two scale stages, accumulate and the result register.
// Reset clears config registers and all valid bits; the body table is not cleared.
// A stalled result freezes the whole pipe; nothing is dropped or repeated.
module particle_gravity_step_unit import pgs_pkg::*; #(
	parameter int MAX_BODIES = MAX_BODIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// advance every stage unless a finished word waits on a stalled output
	logic en;
	logic out_vld_q;
	result_t res_q;

	assign en = !(out_vld_q && result_stall);

	// config registers
	logic signed [31:0] offset_x_q, offset_y_q, offset_z_q;
	logic [3:0]         body_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q   <= '0;
			offset_y_q   <= '0;
			offset_z_q   <= '0;
			body_count_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_OFFSET_X:   offset_x_q   <= cfg_data;
				CFG_OFFSET_Y:   offset_y_q   <= cfg_data;
				CFG_OFFSET_Z:   offset_z_q   <= cfg_data;
				CFG_BODY_COUNT: body_count_q <= cfg_data[3:0];
			endcase
		end
	end

	// front end: table, sequencer, distances, numerator
	logic fb_vld;
	fb_t  fb;

	pgs_front #(
		.MAX_BODIES(MAX_BODIES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.item_valid(item_valid),
		.item      (item),
		.item_stall(item_stall),
		.offset_x  (offset_x_q),
		.offset_y  (offset_y_q),
		.offset_z  (offset_z_q),
		.body_count(body_count_q),
		.fb_vld    (fb_vld),
		.fb        (fb)
	);

	// distance length: floor(sqrt(d2)), Q16.16
	logic        sq_vld;
	logic [31:0] len;
	fb_t         sq_fb;

	pgs_sqrt_pipe #(
		.RW(32),
		.SW($bits(fb_t))
	) u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.vld_i (fb_vld),
		.x     (fb.d2),
		.sb_i  (fb),
		.vld_o (sq_vld),
		.root  (len),
		.sb_o  (sq_fb)
	);

	// acceleration magnitude and unit direction, all four dividers in lockstep
	logic        dv_vld;
	logic [63:0] accel;
	ab_t         ab_in, ab_d;
	logic [63:0] uq [3];
	logic [2:0]  rneg_d;

	assign ab_in = '{tok: sq_fb.tok, skip: sq_fb.skip};

	pgs_div_pipe #(
		.NW(64),
		.SW($bits(ab_t))
	) u_div_acc (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.vld_i (sq_vld),
		.num   (sq_fb.t),
		.den   (sq_fb.d2),
		.sb_i  (ab_in),
		.vld_o (dv_vld),
		.quo   (accel),
		.sb_o  (ab_d)
	);

	for (genvar j = 0; j < 3; j++) begin : g_udiv
		pgs_div_pipe #(
			.NW(64),
			.SW(1)
		) u_div_dir (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.vld_i (sq_vld),
			.num   ({2'b00, sq_fb.rmag[j], 30'd0}),
			.den   ({32'd0, len}),
			.sb_i  (sq_fb.rneg[j]),
			.vld_o (),
			.quo   (uq[j]),
			.sb_o  (rneg_d[j])
		);
	end

	// scale stage 1: split accel * u into two partial products over the 32-bit halves of accel
	logic        vld_p1;
	ab_t         ab_p1;
	logic [2:0]  rneg_p1;
	logic [62:0] lo_p1 [3];
	logic [62:0] hi_p1 [3];
	logic [62:0] lo_c [3];
	logic [62:0] hi_c [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			lo_c[j] = 63'(accel[31:0]) * 63'(uq[j][30:0]);
			hi_c[j] = 63'(accel[63:32]) * 63'(uq[j][30:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ab_p1   <= ab_d;
			rneg_p1 <= rneg_d;
			for (int j = 0; j < 3; j++) begin
				lo_p1[j] <= lo_c[j];
				hi_p1[j] <= hi_c[j];
			end
		end
	end

	// scale stage 2: combine, drop the Q2.30 fraction, cap the step
	logic        vld_p2;
	ab_t         ab_p2;
	logic [2:0]  rneg_p2;
	logic [32:0] term_p2 [3];
	logic [95:0] sum_c [3];
	logic [65:0] sh_c [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sum_c[j] = (96'(hi_p1[j]) << 32) + 96'(lo_p1[j]);
			sh_c[j]  = sum_c[j][95:30];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ab_p2   <= ab_p1;
			rneg_p2 <= rneg_p1;
			for (int j = 0; j < 3; j++) begin
				term_p2[j] <= (sh_c[j] > 66'(TERM_CAP)) ? TERM_CAP : sh_c[j][32:0];
			end
		end
	end

	// accumulate: the first token of a particle seeds the velocity,
	// skipped bodies leave it alone, each step saturates
	logic signed [31:0] acc_q [3];
	logic signed [31:0] cur_c [3];
	logic signed [31:0] nxt_c [3];
	logic signed [35:0] step_c [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			cur_c[j]  = ab_p2.tok.first ? $signed(ab_p2.tok.vel[j]) : acc_q[j];
			step_c[j] = $signed({3'b000, term_p2[j]});
			if (ab_p2.skip) begin
				nxt_c[j] = cur_c[j];
			end else if (rneg_p2[j]) begin
				nxt_c[j] = sat32(36'(cur_c[j]) - step_c[j]);
			end else begin
				nxt_c[j] = sat32(36'(cur_c[j]) + step_c[j]);
			end
		end
	end

	logic               vld_f;
	logic [2:0][31:0]   pos_f;
	logic signed [31:0] vel_f [3];

	always_ff @(posedge clk) begin
		if (en && vld_p2) begin
			for (int j = 0; j < 3; j++) begin
				acc_q[j] <= nxt_c[j];
			end
			if (ab_p2.tok.last) begin
				pos_f <= ab_p2.tok.pos;
				for (int j = 0; j < 3; j++) begin
					vel_f[j] <= nxt_c[j];
				end
			end
		end
	end

	// result register: position gains the new velocity
	logic signed [31:0] npos_c [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			npos_c[j] = sat32(36'($signed(pos_f[j])) + 36'(vel_f[j]));
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_f) begin
			res_q <= '{new_pos_x: npos_c[0], new_pos_y: npos_c[1], new_pos_z: npos_c[2],
				new_vel_x: vel_f[0], new_vel_y: vel_f[1], new_vel_z: vel_f[2]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p1    <= 1'b0;
			vld_p2    <= 1'b0;
			vld_f     <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_p1    <= dv_vld;
			vld_p2    <= vld_p1;
			vld_f     <= vld_p2 && ab_p2.tok.last;
			out_vld_q <= vld_f;
		end
	end

	assign result_valid = out_vld_q;
	assign result       = res_q;

`ifndef SYNTHESIS
	a_last_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		vld_p2 && ab_p2.tok.last && en |=> vld_f)
		else $error("last body of a particle produced no result");
	a_term_cap: assert property (@(posedge clk) disable iff (!arst_n)
		vld_p2 |-> (term_p2[0] <= TERM_CAP) && (term_p2[1] <= TERM_CAP)
			&& (term_p2[2] <= TERM_CAP))
		else $error("velocity step above cap");
	a_unit_dir: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld && !ab_d.skip |-> (uq[0] <= 64'(UNIT_Q30)) && (uq[1] <= 64'(UNIT_Q30))
			&& (uq[2] <= 64'(UNIT_Q30)))
		else $error("direction component longer than one");
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> out_vld_q && $stable(vld_p2) && $stable(vld_f))
		else $error("pipe moved while the result was stalled");
`endif

endmodule

/* tb/tb.sv */
// Self-checking bench for particle_gravity_step_unit: loads bodies, streams particles,
// predicts every updated particle and checks it. Depends on pgs_pkg and the RTL top.
`timescale 1ns / 1ps

import pgs_pkg::*;

class gravity_scoreboard;
	logic signed [31:0] off [3];
	logic [3:0] bcount;
	logic signed [31:0] bpos [8][3];
	logic [31:0] bmass [8];
	result_t particle_q [$];
	int errors;

	function new();
		foreach (off[i]) off[i] = 0;
		bcount = 0;
		errors = 0;
	endfunction

	function longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function bit [63:0] root64(bit [63:0] x);
		bit [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function void set_reg(cfg_idx_t idx, logic [31:0] data);
		case (idx)
			CFG_OFFSET_X: off[0] = data;
			CFG_OFFSET_Y: off[1] = data;
			CFG_OFFSET_Z: off[2] = data;
			CFG_BODY_COUNT: bcount = data[3:0];
		endcase
	endfunction

	// note an accepted word: load a body or queue the updated particle
	function void note(item_t it);
		longint p [3], v [3], b [3], r [3];
		bit [63:0] mag [3];
		bit [63:0] d2, len, t, accel, u, term;
		bit [127:0] prod, w;
		int n;
		result_t res;
		if (it.operation == OP_LOAD) begin
			bpos[it.body_index][0] = it.pos_x;
			bpos[it.body_index][1] = it.pos_y;
			bpos[it.body_index][2] = it.pos_z;
			bmass[it.body_index] = it.mass;
			return;
		end
		p[0] = it.pos_x; p[1] = it.pos_y; p[2] = it.pos_z;
		v[0] = it.vel_x; v[1] = it.vel_y; v[2] = it.vel_z;
		n = (bcount > 8) ? 8 : bcount;
		for (int k = 0; k < n; k++) begin
			d2 = 0;
			for (int j = 0; j < 3; j++) begin
				b[j] = bpos[k][j];
				r[j] = clamp32(b[j] - (p[j] + longint'(off[j])));
				mag[j] = (r[j] < 0) ? -r[j] : r[j];
				d2 += mag[j] * mag[j];
			end
			if (d2 == 0) continue;	// coincident body contributes nothing
			len = root64(d2);
			prod = 128'(GDT_Q48) * (128'(bmass[k]) * 128'(it.mass));
			t = prod[95:32];
			accel = t / d2;
			for (int j = 0; j < 3; j++) begin
				u = (mag[j] << 30) / len;
				w = 128'(accel) * 128'(u);
				if (w[127:64] != 0) term = 64'h1_0000_0000;
				else begin
					term = w[63:0] >> 30;
					if (term > 64'h1_0000_0000) term = 64'h1_0000_0000;
				end
				if (r[j] < 0) v[j] = clamp32(v[j] - longint'(term));
				else v[j] = clamp32(v[j] + longint'(term));
			end
		end
		res.new_pos_x = 32'(clamp32(p[0] + v[0]));
		res.new_pos_y = 32'(clamp32(p[1] + v[1]));
		res.new_pos_z = 32'(clamp32(p[2] + v[2]));
		res.new_vel_x = 32'(v[0]);
		res.new_vel_y = 32'(v[1]);
		res.new_vel_z = 32'(v[2]);
		particle_q.insert(particle_q.size(), res);
	endfunction

	function void check(result_t got);
		result_t exp;
		string names [6];
		names = '{"new_pos_x", "new_pos_y", "new_pos_z", "new_vel_x", "new_vel_y",
			"new_vel_z"};
		if (particle_q.size() == 0) begin
			$display("%0t: unexpected result word %h", $time, got);
			errors++;
			return;
		end
		exp = particle_q.pop_front();
		for (int i = 0; i < 6; i++) begin
			if (exp[191 - 32 * i -: 32] !== got[191 - 32 * i -: 32]) begin
				$display("%0t: %s expected %h actual %h", $time, names[i],
					exp[191 - 32 * i -: 32], got[191 - 32 * i -: 32]);
				errors++;
			end
		end
	endfunction
endclass

module tb;
	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	logic        cfg_wen;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	gravity_scoreboard sb;
	int send_idle;		// percent of cycles the sender holds off
	int recv_idle;		// percent of cycles the receiver stalls
	int hold_cycles;	// long receiver hold-off, counted down below

	particle_gravity_step_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// receiver: pick the stall at the falling edge, a long hold-off takes priority
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			result_stall = 1'b1;
			hold_cycles--;
		end else begin
			result_stall = ($urandom_range(99) < recv_idle);
		end
	end

	// check every result word taken at the rising edge
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) sb.check(result);
	end

	// coordinate spread over many magnitudes so both tiny and huge distances occur
	function automatic logic [31:0] rand_coord();
		logic [31:0] v;
		int sh;
		if ($urandom_range(4) == 0) return $urandom;
		sh = $urandom_range(4, 31);
		v = $urandom & ((32'd1 << sh) - 1);
		return $urandom_range(1) ? -v : v;
	endfunction

	function automatic logic [31:0] rand_mass();
		if ($urandom_range(3) == 0) return $urandom;
		return $urandom >> $urandom_range(0, 31);
	endfunction

	// offer one word, wait for it to be taken, then note it
	task automatic send_word(item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		item = it;
		do @(posedge clk); while (item_stall);
		sb.note(it);
	endtask

	task automatic send_body(int slot, logic [31:0] x, logic [31:0] y, logic [31:0] z,
		logic [31:0] m);
		item_t it;
		it = '0;
		it.operation = OP_LOAD;
		it.body_index = 3'(slot);
		it.pos_x = x; it.pos_y = y; it.pos_z = z;
		it.mass = $urandom;
		it.vel_x = $urandom; it.vel_y = $urandom; it.vel_z = $urandom;
		it.mass = m;
		send_word(it);
	endtask

	task automatic send_particle(logic [31:0] x, logic [31:0] y, logic [31:0] z,
		logic [31:0] vx, logic [31:0] vy, logic [31:0] vz, logic [31:0] m);
		item_t it;
		it.operation = OP_UPDATE;
		it.body_index = 3'($urandom);
		it.pos_x = x; it.pos_y = y; it.pos_z = z;
		it.vel_x = vx; it.vel_y = vy; it.vel_z = vz;
		it.mass = m;
		send_word(it);
	endtask

	// drain the pipe, then let trailing body loads settle before a register write
	task automatic wait_idle();
		@(negedge clk);
		item_valid = 1'b0;
		while (sb.particle_q.size() != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
		@(negedge clk);
		cfg_wen = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_wen = 1'b0;
	endtask

	task automatic write_all(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
		logic [3:0] cnt);
		write_reg(CFG_OFFSET_X, ox);
		write_reg(CFG_OFFSET_Y, oy);
		write_reg(CFG_OFFSET_Z, oz);
		write_reg(CFG_BODY_COUNT, {28'd0, cnt});
	endtask

	task automatic send_random();
		if ($urandom_range(99) < 15) begin
			send_body($urandom_range(7), rand_coord(), rand_coord(), rand_coord(), rand_mass());
		end else begin
			send_particle(rand_coord(), rand_coord(), rand_coord(),
				rand_coord(), rand_coord(), rand_coord(), rand_mass());
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = CFG_OFFSET_X;
		cfg_data = '0;
		hold_cycles = 0;
		send_idle = 33;
		recv_idle = 58;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fill every slot first so no unloaded entry is ever read
		send_body(0, 0, 0, 0, 32'h0001_0000);
		send_body(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_body(2, 32'h0001_0000, 0, 0, 32'hFFFF_FFFF);
		send_body(3, 32'hFFFF_0000, 32'h0000_8000, 32'h0000_0001, 32'h0000_0000);
		for (int s = 4; s < 8; s++) send_body(s, rand_coord(), rand_coord(), rand_coord(),
			rand_mass());

		// no bodies: velocity passes through, position saturates both ways
		send_particle(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1,
			32'hFFFF_FFFF);
		send_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
		wait_idle();

		// all eight bodies; the first particle sits on body 0
		write_reg(CFG_BODY_COUNT, 8);
		send_particle(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
		send_particle(32'h0000_0001, 0, 0, 32'h0000_1000, 0, 0, 32'hFFFF_FFFF);
		send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF);
		send_particle(32'h0001_0000, 32'h0000_0001, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1);
		wait_idle();

		// body count above the table size, offsets at the extremes
		write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 4'd15);
		send_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 32'hFFFF_FFFF);
		send_particle(0, 0, 0, 0, 0, 0, 32'h0010_0000);
		wait_idle();
		write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 4'd1);
		send_particle(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 32'hFFFF_FFFF);
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_all(0, 0, 0, 4'd8);
				1: write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 4'd15);
				2: write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 4'd0);
				default: write_all(rand_coord(), rand_coord(), rand_coord(),
					4'($urandom_range(1, 15)));
			endcase
			if (ph < 2) begin
				send_idle = 33;
				recv_idle = 58;
			end else if (ph < 4) begin
				send_idle = 58;
				recv_idle = 33;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			// hold the result side long enough to back the pipe up into the input
			if (ph == 1 || ph == 4) hold_cycles = 800;
			repeat (215) send_random();
			wait_idle();
		end

		if (sb.errors == 0 && sb.particle_q.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb NOT OK");
		$finish;
	end
endmodule
